>>> sv/ckc_pkg.sv
// ----------------------------------------------------------------------------
// ckc_pkg: shared types and constants for the color key centroid unit
// Holds the register map, the item and queue head records and the divider
// request/status records used between the front, back and divider.
// ----------------------------------------------------------------------------
package ckc_pkg;

   // Field widths
   localparam int CHAN_W  = 8;
   localparam int X_W     = 10;
   localparam int Y_W     = 9;
   localparam int SUM_W   = 28;
   localparam int CNT_W   = 19;
   localparam int DIM_W   = 13;   // holds frame sizes up to 8191

   // Stream packing
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 24;

   // Configuration port
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [1:0] {
      CSR_KEY_RED   = 2'd0,
      CSR_KEY_GREEN = 2'd1,
      CSR_KEY_BLUE  = 2'd2,
      CSR_TOLERANCE = 2'd3
   } csr_idx_type;

   localparam logic [CHAN_W-1:0] KEY_RED_RST   = 8'd170;
   localparam logic [CHAN_W-1:0] KEY_GREEN_RST = 8'd140;
   localparam logic [CHAN_W-1:0] KEY_BLUE_RST  = 8'd120;
   localparam logic [CHAN_W-1:0] TOLERANCE_RST = 8'd40;

   // Queue between front and back
   localparam int QUEUE_AW    = 2;
   localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

   // Divider step count
   localparam int DIV_CNT_W = 5;
   localparam logic [DIV_CNT_W-1:0] DIV_LAST_STEP = DIV_CNT_W'(SUM_W - 1);

   // Centroid saturation limits
   localparam logic [X_W-1:0] CX_MAX = {X_W{1'b1}};
   localparam logic [Y_W-1:0] CY_MAX = {Y_W{1'b1}};

   // Classified pixel as queued for the back end
   typedef struct packed {
      logic           match;
      logic           last;
      logic [X_W-1:0] px;
      logic [Y_W-1:0] py;
   } item_type;

   // Key colour configuration
   typedef struct packed {
      logic [CHAN_W-1:0] key_red;
      logic [CHAN_W-1:0] key_green;
      logic [CHAN_W-1:0] key_blue;
      logic [CHAN_W-1:0] tolerance;
   } key_cfg_type;

   // Divider request and status
   typedef struct packed {
      logic             start;
      logic [SUM_W-1:0] dividend;
      logic [CNT_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [SUM_W-1:0] quotient;
   } div_stat_type;

   // Queue head as seen by the back end
   typedef struct packed {
      logic     valid;
      item_type item;
   } head_type;

endpackage

>>> sv/ckc_front.sv
// ----------------------------------------------------------------------------
// ckc_front: pixel classifier and item queue
// Tests each accepted pixel against the key colour window and the frame
// bounds and stores the classified item in a small queue for the back end.
// ----------------------------------------------------------------------------
module ckc_front
   import ckc_pkg::*;
#(
   parameter int FRAME_WIDTH  = 640,
   parameter int FRAME_HEIGHT = 480
) (
   input  logic              clock,
   input  logic              reset,
   input  key_cfg_type       cfg,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [CHAN_W-1:0] red,
   input  logic [CHAN_W-1:0] green,
   input  logic [CHAN_W-1:0] blue,
   input  logic [X_W-1:0]    pixel_x,
   input  logic [Y_W-1:0]    pixel_y,
   input  logic              frame_end,
   output head_type          head,
   input  logic              pop
);

   logic [QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]   count_ff, count_in;
   item_type            queue_mem [QUEUE_DEPTH];
   item_type            item_new;
   logic                push;
   logic                inside_frame;
   logic                red_ok, green_ok, blue_ok;

   // Strict window test k - tol < c < k + tol, done in 9 bits so nothing wraps
   function automatic logic chan_inside(input logic [CHAN_W-1:0] c,
                                        input logic [CHAN_W-1:0] k,
                                        input logic [CHAN_W-1:0] tol);
      logic [CHAN_W:0] c_plus_t;
      logic [CHAN_W:0] k_plus_t;
      c_plus_t = {1'b0, c} + {1'b0, tol};
      k_plus_t = {1'b0, k} + {1'b0, tol};
      return (c_plus_t > {1'b0, k}) && ({1'b0, c} < k_plus_t);
   endfunction

   // Classify
   always_comb begin
      inside_frame = (DIM_W'(pixel_x) < DIM_W'(FRAME_WIDTH)) &&
                     (DIM_W'(pixel_y) < DIM_W'(FRAME_HEIGHT));
      red_ok   = chan_inside(red,   cfg.key_red,   cfg.tolerance);
      green_ok = chan_inside(green, cfg.key_green, cfg.tolerance);
      blue_ok  = chan_inside(blue,  cfg.key_blue,  cfg.tolerance);
      item_new.match = inside_frame && red_ok && green_ok && blue_ok;
      item_new.last  = frame_end;
      item_new.px    = pixel_x;
      item_new.py    = pixel_y;
   end

   // Queue control
   assign in_ready   = (count_ff != (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign push       = in_valid && in_ready;
   assign head.valid = (count_ff != '0);
   assign head.item  = queue_mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         queue_mem[wr_ptr_ff] <= item_new;
      end
   end

endmodule

>>> sv/ckc_div.sv
// ----------------------------------------------------------------------------
// ckc_div: iterative unsigned divider
// Restoring division of a 28-bit sum by a 19-bit count, one quotient bit
// per cycle; done pulses for one cycle when the quotient is ready.
// ----------------------------------------------------------------------------
module ckc_div
   import ckc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  div_req_type  req,
   output div_stat_type stat
);

   logic [CNT_W-1:0]     rem_ff, rem_in;
   logic [SUM_W-1:0]     quo_ff, quo_in;
   logic [CNT_W-1:0]     den_ff, den_in;
   logic [DIV_CNT_W-1:0] step_ff, step_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_W:0]       trial;
   logic                 fits;

   // One restoring step: shift in the next dividend bit, subtract if it fits
   always_comb begin
      trial   = {rem_ff, quo_ff[SUM_W-1]};
      fits    = (trial >= {1'b0, den_ff});
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         rem_in  = '0;
         quo_in  = req.dividend;
         den_in  = req.divisor;
         step_in = DIV_LAST_STEP;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? CNT_W'(trial - {1'b0, den_ff}) : trial[CNT_W-1:0];
         quo_in  = {quo_ff[SUM_W-2:0], fits};
         step_in = step_ff - 1'b1;
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign stat.busy     = busy_ff;
   assign stat.done     = done_ff;
   assign stat.quotient = quo_ff;

endmodule

>>> sv/ckc_back.sv
// ----------------------------------------------------------------------------
// ckc_back: accumulator, centroid sequencer and result register
// Sums the coordinates of matching pixels, runs the two divisions on a frame
// end with matches and holds each result until the downstream side takes it.
// ----------------------------------------------------------------------------
module ckc_back
   import ckc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  head_type        head,
   output logic            pop,
   output div_req_type     div_req,
   input  div_stat_type    div_stat,
   output logic            out_valid,
   input  logic            out_ready,
   output logic            pixel_match,
   output logic            centroid_valid,
   output logic [X_W-1:0]  centroid_x,
   output logic [Y_W-1:0]  centroid_y
);

   typedef enum logic [3:0] {
      ST_RUN  = 4'b0001,
      ST_DIVX = 4'b0010,
      ST_DIVY = 4'b0100,
      ST_EMIT = 4'b1000
   } state_type;

   state_type        state_ff, state_in;
   logic [SUM_W-1:0] col_sum_ff, col_sum_in;
   logic [SUM_W-1:0] row_sum_ff, row_sum_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [SUM_W-1:0] row_op_ff, row_op_in;
   logic [CNT_W-1:0] cnt_op_ff, cnt_op_in;
   logic             match_op_ff, match_op_in;
   logic [X_W-1:0]   cx_ff, cx_in;
   logic             out_valid_ff, out_valid_in;
   logic             out_match_ff, out_match_in;
   logic             out_cvalid_ff, out_cvalid_in;
   logic [X_W-1:0]   out_cx_ff, out_cx_in;
   logic [Y_W-1:0]   out_cy_ff, out_cy_in;
   logic             out_free;
   logic [SUM_W-1:0] col_next, row_next;
   logic [CNT_W-1:0] cnt_next;
   logic [X_W-1:0]   q_x_sat;
   logic [Y_W-1:0]   q_y_sat;

   assign out_free = !out_valid_ff || out_ready;

   // Sums including the pixel at the queue head
   always_comb begin
      col_next = col_sum_ff;
      row_next = row_sum_ff;
      cnt_next = count_ff;
      if (head.item.match) begin
         col_next = col_sum_ff + SUM_W'(head.item.px);
         row_next = row_sum_ff + SUM_W'(head.item.py);
         cnt_next = count_ff + 1'b1;
      end
   end

   // Saturate quotients to the field ranges
   assign q_x_sat = (div_stat.quotient[SUM_W-1:X_W] != '0) ? CX_MAX
                                                          : div_stat.quotient[X_W-1:0];
   assign q_y_sat = (div_stat.quotient[SUM_W-1:Y_W] != '0) ? CY_MAX
                                                          : div_stat.quotient[Y_W-1:0];

   // Sequencer
   always_comb begin
      state_in         = state_ff;
      col_sum_in       = col_sum_ff;
      row_sum_in       = row_sum_ff;
      count_in         = count_ff;
      row_op_in        = row_op_ff;
      cnt_op_in        = cnt_op_ff;
      match_op_in      = match_op_ff;
      cx_in            = cx_ff;
      out_valid_in     = out_valid_ff && !out_ready;
      out_match_in     = out_match_ff;
      out_cvalid_in    = out_cvalid_ff;
      out_cx_in        = out_cx_ff;
      out_cy_in        = out_cy_ff;
      pop              = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = col_next;
      div_req.divisor  = cnt_next;
      unique case (state_ff)
         ST_RUN: begin
            if (head.valid && out_free) begin
               pop = 1'b1;
               if (!head.item.last) begin
                  col_sum_in    = col_next;
                  row_sum_in    = row_next;
                  count_in      = cnt_next;
                  out_valid_in  = 1'b1;
                  out_match_in  = head.item.match;
                  out_cvalid_in = 1'b0;
                  out_cx_in     = '0;
                  out_cy_in     = '0;
               end else begin
                  // Frame end closes the frame and clears the sums
                  col_sum_in  = '0;
                  row_sum_in  = '0;
                  count_in    = '0;
                  row_op_in   = row_next;
                  cnt_op_in   = cnt_next;
                  match_op_in = head.item.match;
                  if (cnt_next == '0) begin
                     out_valid_in  = 1'b1;
                     out_match_in  = head.item.match;
                     out_cvalid_in = 1'b0;
                     out_cx_in     = '0;
                     out_cy_in     = '0;
                  end else begin
                     div_req.start = 1'b1;
                     state_in      = ST_DIVX;
                  end
               end
            end
         end
         ST_DIVX: begin
            div_req.dividend = row_op_ff;
            div_req.divisor  = cnt_op_ff;
            if (div_stat.done) begin
               cx_in         = q_x_sat;
               div_req.start = 1'b1;
               state_in      = ST_DIVY;
            end
         end
         ST_DIVY: begin
            div_req.dividend = row_op_ff;
            div_req.divisor  = cnt_op_ff;
            if (div_stat.done) begin
               out_cy_in = q_y_sat;
               state_in  = ST_EMIT;
            end
         end
         ST_EMIT: begin
            div_req.dividend = row_op_ff;
            div_req.divisor  = cnt_op_ff;
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_match_in  = match_op_ff;
               out_cvalid_in = 1'b1;
               out_cx_in     = cx_ff;
               state_in      = ST_RUN;
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         col_sum_ff   <= '0;
         row_sum_ff   <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_sum_ff   <= col_sum_in;
         row_sum_ff   <= row_sum_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      row_op_ff     <= row_op_in;
      cnt_op_ff     <= cnt_op_in;
      match_op_ff   <= match_op_in;
      cx_ff         <= cx_in;
      out_match_ff  <= out_match_in;
      out_cvalid_ff <= out_cvalid_in;
      out_cx_ff     <= out_cx_in;
      out_cy_ff     <= out_cy_in;
   end

   assign out_valid      = out_valid_ff;
   assign pixel_match    = out_match_ff;
   assign centroid_valid = out_cvalid_ff;
   assign centroid_x     = out_cx_ff;
   assign centroid_y     = out_cy_ff;

endmodule

>>> sv/color_key_centroid_unit.sv
// An ordinary pixel's item is registered in the queue, then its result in the output register.
// Throughput: 1 pixel per cycle unless rsp_tready stalls the output; a frame end
// with matches holds the back end for two 28-step divisions on the shared divider.
// A 4-entry queue lets the input keep taking pixels during the divisions until it is full.
// Reset: synchronous, active high; clears sums, queue and output valid and
// loads the key colour 170/140/120 with tolerance 40.
// ----------------------------------------------------------------------------
// color_key_centroid_unit: colour key match and blob centroid
// Marks pixels inside the key colour window, accumulates the coordinates of
// matching pixels and returns their mean on each frame end with matches.
// ----------------------------------------------------------------------------
module color_key_centroid_unit
   import ckc_pkg::*;
#(
   parameter int FRAME_WIDTH  = 640,
   parameter int FRAME_HEIGHT = 480
) (
   input  logic                  clock,
   input  logic                  reset,
   // Pixel input
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // red, green, blue, pixel_x, pixel_y, pad
   input  logic                  req_tlast,   // frame_end
   // Result output
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // pixel_match, centroid_x, centroid_y, pad
   output logic                  rsp_tuser,   // centroid_valid
   // Configuration
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   key_cfg_type  cfg_ff, cfg_in;
   head_type     head;
   logic         pop;
   div_req_type  div_req;
   div_stat_type div_stat;
   logic         csr_wr;
   csr_idx_type  csr_idx;
   logic         pixel_match, centroid_valid;
   logic [X_W-1:0] centroid_x;
   logic [Y_W-1:0] centroid_y;

   // Register file
   assign csr_pready = 1'b1;
   assign csr_idx    = csr_idx_type'(csr_paddr[3:2]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         unique case (csr_idx)
            CSR_KEY_RED:   cfg_in.key_red   = csr_pwdata[CHAN_W-1:0];
            CSR_KEY_GREEN: cfg_in.key_green = csr_pwdata[CHAN_W-1:0];
            CSR_KEY_BLUE:  cfg_in.key_blue  = csr_pwdata[CHAN_W-1:0];
            CSR_TOLERANCE: cfg_in.tolerance = csr_pwdata[CHAN_W-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         CSR_KEY_RED:   csr_prdata = CSR_DATA_W'(cfg_ff.key_red);
         CSR_KEY_GREEN: csr_prdata = CSR_DATA_W'(cfg_ff.key_green);
         CSR_KEY_BLUE:  csr_prdata = CSR_DATA_W'(cfg_ff.key_blue);
         CSR_TOLERANCE: csr_prdata = CSR_DATA_W'(cfg_ff.tolerance);
         default:       csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.key_red   <= KEY_RED_RST;
         cfg_ff.key_green <= KEY_GREEN_RST;
         cfg_ff.key_blue  <= KEY_BLUE_RST;
         cfg_ff.tolerance <= TOLERANCE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Classifier and queue
   ckc_front #(
      .FRAME_WIDTH  (FRAME_WIDTH),
      .FRAME_HEIGHT (FRAME_HEIGHT)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .red       (req_tdata[7:0]),
      .green     (req_tdata[15:8]),
      .blue      (req_tdata[23:16]),
      .pixel_x   (req_tdata[33:24]),
      .pixel_y   (req_tdata[42:34]),
      .frame_end (req_tlast),
      .head      (head),
      .pop       (pop)
   );

   // Accumulator and result register
   ckc_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .pop            (pop),
      .div_req        (div_req),
      .div_stat       (div_stat),
      .out_valid      (rsp_tvalid),
      .out_ready      (rsp_tready),
      .pixel_match    (pixel_match),
      .centroid_valid (centroid_valid),
      .centroid_x     (centroid_x),
      .centroid_y     (centroid_y)
   );

   // Shared divider
   ckc_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .stat  (div_stat)
   );

   assign rsp_tdata = {4'b0, centroid_y, centroid_x, pixel_match};
   assign rsp_tuser = centroid_valid;

`ifndef SYNTHESIS
   // A result without a centroid carries zero coordinates
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata[19:1] == '0))
      else $error("coordinates set on a result without centroid");

   // The divider is never restarted mid-division
   assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !div_stat.busy)
      else $error("divider started while busy");

   // Reset leaves no result pending
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // A queue pop only happens when the queue holds an item
   assert property (@(posedge clock) disable iff (reset)
      pop |-> head.valid)
      else $error("pop from empty queue");
`endif

endmodule
